/* hdl/sliding_median_spike_alert_defines.svh */
// Assertion macros used by the top RTL file of the sliding median spike alert.
`ifndef SLIDING_MEDIAN_SPIKE_ALERT_DEFINES_SVH
`define SLIDING_MEDIAN_SPIKE_ALERT_DEFINES_SVH

`ifndef ASSERT_OFF

`define SMSA_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

`define SMSA_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`define SMSA_ASSERT_ALWAYS(lbl, ck, rs, cond, msg) \
  `SMSA_ASSERT_IMP(lbl, ck, rs, 1'b1, cond, msg)

`else

`define SMSA_ASSERT_IMP(lbl, ck, rs, ante, cons, msg)

`define SMSA_ASSERT_NXT(lbl, ck, rs, ante, cons, msg)

`define SMSA_ASSERT_ALWAYS(lbl, ck, rs, cond, msg)

`endif

`endif

/* hdl/smsa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package smsa_pkg;

  localparam int CFG_W = 9;
  localparam int COUNT_W = 32;
  localparam logic [CFG_W-1:0] LEN_RESET = 9'd5;

  typedef enum logic {
    ST_IDLE,
    ST_SETTLE
  } state_t;

  typedef struct packed {
    logic load;
    logic remove;
  } cell_ctrl_t;

  // Register stages of a four-way reduction tree over n leaves.
  function automatic int tree_levels(input int n);
    int lv;
    if (n <= 4) begin
      lv = 1;
    end else begin
      lv = ($clog2(n) + 1) / 2;
    end
    return lv;
  endfunction

endpackage

`default_nettype wire

/* hdl/smsa_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module smsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/smsa_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module smsa_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int WINDOW_MAX = 256,
  parameter int INDEX = 0,
  parameter int LEN_W = $clog2(WINDOW_MAX + 1),
  parameter int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
  input  wire logic                       clk,
  input  wire smsa_pkg::cell_ctrl_t       ctrl,
  input  wire logic [SAMPLE_BITS-1:0]     rm_val,
  input  wire logic [SAMPLE_BITS-1:0]     sample,
  input  wire logic [LEN_W-1:0]           ins_count,
  input  wire logic [IDX_W-1:0]           lo_idx,
  input  wire logic [IDX_W-1:0]           hi_idx,
  input  wire logic [SAMPLE_BITS-1:0]     v_right,
  input  wire logic [SAMPLE_BITS-1:0]     w_left,
  input  wire logic                       ltw_left,
  output logic      [SAMPLE_BITS-1:0]     value,
  output logic      [SAMPLE_BITS-1:0]     w_out,
  output logic                            ltw_out,
  output logic      [2*SAMPLE_BITS-1:0]   tap
);

  import smsa_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
  localparam logic [LEN_W-1:0] MY_POS = LEN_W'(INDEX);

  logic                   shift_left;
  logic [SAMPLE_BITS-1:0] value_next;

  // The oldest sample leaves first, then the new sample goes in front of
  // the first entry that is not below it.
  always_comb begin
    shift_left = ctrl.remove && (value >= rm_val);
    w_out = shift_left ? v_right : value;
    ltw_out = (MY_POS < ins_count) && (w_out < sample);
    if (ltw_out) begin
      value_next = w_out;
    end else if (ltw_left) begin
      value_next = sample;
    end else begin
      value_next = w_left;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      value <= value_next;
    end
  end

  assign tap = {(MY_IDX == hi_idx) ? value : '0, (MY_IDX == lo_idx) ? value : '0};

endmodule

`default_nettype wire

/* hdl/smsa_tap_tree.sv */
`timescale 1ns / 1ps
`default_nettype none

module smsa_tap_tree #(
  parameter int N = 256,
  parameter int WIDTH = 32
) (
  input  wire logic                    clk,
  input  wire logic [N-1:0][WIDTH-1:0] leaf,
  output logic      [WIDTH-1:0]        root
);

  import smsa_pkg::*;

  localparam int LEVELS = tree_levels(N);
  localparam int PAD = 4 ** LEVELS;
  localparam int INNER = (PAD - 1) / 3;

  logic [WIDTH-1:0] node [INNER];
  logic [WIDTH-1:0] all_nodes [INNER + PAD];

  for (genvar i = 0; i < INNER + PAD; i++) begin : g_all
    if (i < INNER) begin : g_inner
      assign all_nodes[i] = node[i];
    end else if (i - INNER < N) begin : g_leaf
      assign all_nodes[i] = leaf[i - INNER];
    end else begin : g_pad
      assign all_nodes[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < INNER; i++) begin
      node[i] <= all_nodes[4*i+1] | all_nodes[4*i+2] | all_nodes[4*i+3] | all_nodes[4*i+4];
    end
  end

  assign root = node[0];

endmodule

`default_nettype wire

/* hdl/sliding_median_spike_alert.sv */
// Sliding-window median spike detector. Each input item carries one unsigned
// sample; each accepted item yields exactly one result item. Once the window
// of window_length samples is full, a sample at or above twice the window
// median raises alert and bumps a saturating alert count; the sample that
// fills the window is only stored. The window lives in a row of
// compare-and-shift cells that drop the oldest sample and insert the new one
// together, with the arrival order kept in a small RAM. The median
// taps are collected by a registered four-way OR tree of
// L = max(1, ceil(log4(WINDOW_MAX))) stages, and no new item is accepted
// until the tree has settled on the last one. Writing window_length empties
// the window but keeps the alert count; a length of 0 acts as 1 and a
// length above WINDOW_MAX acts as WINDOW_MAX. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_median_spike_alert_defines.svh"

module sliding_median_spike_alert #(
  parameter int WINDOW_MAX = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire logic                                       cfg_wr_en,
  input  wire logic [smsa_pkg::CFG_W-1:0]                 cfg_wr_data,
  input  wire logic                                       s_axis_tvalid,
  output logic                                            s_axis_tready,
  // sample
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]           s_axis_tdata,
  output logic                                            m_axis_tvalid,
  input  wire logic                                       m_axis_tready,
  // alert, window_full, twice_median, alert_count
  output logic [((SAMPLE_BITS+smsa_pkg::COUNT_W+10)/8)*8-1:0] m_axis_tdata
);

  import smsa_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int OUT_W = ((SAMPLE_BITS + COUNT_W + 10) / 8) * 8;
  localparam int TREE_LEVELS = tree_levels(WINDOW_MAX);
  localparam int CNT_W = $clog2(TREE_LEVELS + 1);

  state_t               state;
  state_t               state_next;
  logic [CNT_W-1:0]     cnt;
  logic [CFG_W-1:0]     window_length;
  logic [LEN_W-1:0]     fill_level;
  logic [IDX_W-1:0]     oldest_pointer;
  logic [COUNT_W-1:0]   alerts_seen;
  logic [COUNT_W-1:0]   alerts_seen_next;

  logic                 out_alert;
  logic                 out_full;
  logic [SB:0]          out_twice;
  logic [COUNT_W-1:0]   out_count;

  logic                 fire;
  logic [SB-1:0]        sample;
  logic [LEN_W-1:0]     eff_len;
  logic [LEN_W-1:0]     half;
  logic [IDX_W-1:0]     lo_idx;
  logic [IDX_W-1:0]     hi_idx;
  logic                 full;
  logic [SB:0]          twice;
  logic                 alert_hit;
  logic [LEN_W-1:0]     op_inc;
  logic [LEN_W-1:0]     ins_count;
  logic [IDX_W-1:0]     ring_waddr;
  logic [SB-1:0]        ring_rdata;
  cell_ctrl_t           ctrl;

  logic [SB-1:0]                  cell_v   [WINDOW_MAX];
  logic [SB-1:0]                  cell_w   [WINDOW_MAX];
  logic                           cell_ltw [WINDOW_MAX];
  logic [WINDOW_MAX-1:0][2*SB-1:0] taps;
  logic [2*SB-1:0]                root;

  assign sample = s_axis_tdata[SB-1:0];
  assign fire = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (window_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(window_length) > 32'(WINDOW_MAX)) begin
      eff_len = LEN_W'(WINDOW_MAX);
    end else begin
      eff_len = LEN_W'(window_length);
    end
    half = eff_len >> 1;
    hi_idx = IDX_W'(half);
    lo_idx = eff_len[0] ? IDX_W'(half) : IDX_W'(half - LEN_W'(1));
    full = (fill_level == eff_len);
    twice = {1'b0, root[SB-1:0]} + {1'b0, root[2*SB-1:SB]};
    alert_hit = full && ({1'b0, sample} >= twice);
    op_inc = LEN_W'(oldest_pointer) + LEN_W'(1);
    ins_count = full ? (eff_len - LEN_W'(1)) : fill_level;
    ring_waddr = full ? oldest_pointer : IDX_W'(fill_level);
    ctrl.load = fire;
    ctrl.remove = full;
    if (alert_hit && (alerts_seen != '1)) begin
      alerts_seen_next = alerts_seen + COUNT_W'(1);
    end else begin
      alerts_seen_next = alerts_seen;
    end
  end

  smsa_ram #(
    .WIDTH (SB),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (fire),
    .waddr (ring_waddr),
    .wdata (sample),
    .raddr (oldest_pointer),
    .rdata (ring_rdata)
  );

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic [SB-1:0] v_right;
    logic [SB-1:0] w_left;
    logic          ltw_left;

    if (i + 1 < WINDOW_MAX) begin : g_right
      assign v_right = cell_v[i+1];
    end else begin : g_last
      assign v_right = '0;
    end

    if (i == 0) begin : g_first
      assign w_left = '0;
      assign ltw_left = 1'b1;
    end else begin : g_left
      assign w_left = cell_w[i-1];
      assign ltw_left = cell_ltw[i-1];
    end

    smsa_cell #(
      .SAMPLE_BITS (SB),
      .WINDOW_MAX  (WINDOW_MAX),
      .INDEX       (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .rm_val    (ring_rdata),
      .sample    (sample),
      .ins_count (ins_count),
      .lo_idx    (lo_idx),
      .hi_idx    (hi_idx),
      .v_right   (v_right),
      .w_left    (w_left),
      .ltw_left  (ltw_left),
      .value     (cell_v[i]),
      .w_out     (cell_w[i]),
      .ltw_out   (cell_ltw[i]),
      .tap       (taps[i])
    );
  end

  smsa_tap_tree #(
    .N     (WINDOW_MAX),
    .WIDTH (2 * SB)
  ) u_tree (
    .clk  (clk),
    .leaf (taps),
    .root (root)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (fire) begin
          state_next = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        if (cnt == CNT_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    case (state)
      ST_IDLE: begin
        s_axis_tready = !m_axis_tvalid || m_axis_tready;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      window_length <= LEN_RESET;
      fill_level <= '0;
      oldest_pointer <= '0;
      alerts_seen <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        cnt <= CNT_W'(TREE_LEVELS);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
      if (fire) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (fire) begin
        alerts_seen <= alerts_seen_next;
        if (full) begin
          oldest_pointer <= (op_inc == eff_len) ? '0 : IDX_W'(op_inc);
        end else begin
          fill_level <= fill_level + LEN_W'(1);
          oldest_pointer <= '0;
        end
      end else if (cfg_wr_en) begin
        window_length <= cfg_wr_data;
        fill_level <= '0;
        oldest_pointer <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_alert <= alert_hit;
      out_full <= full;
      out_twice <= full ? twice : '0;
      out_count <= alerts_seen_next;
    end
  end

  assign m_axis_tdata = OUT_W'({out_count, out_twice, out_full, out_alert});

  `SMSA_ASSERT_NXT(a_settle_after_item, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken again before the median tree settled")
  `SMSA_ASSERT_ALWAYS(a_fill_bound, clk, rst, fill_level <= eff_len, "fill level beyond the window length")
  `SMSA_ASSERT_IMP(a_alert_needs_full, clk, rst, m_axis_tvalid, !out_alert || out_full, "alert raised while the window was filling")

endmodule

`default_nettype wire
